// File: rtl/pda_pkg.sv
package pda_pkg;

   localparam int MaxBins = 4096;
   localparam int CountW = 13;
   localparam int TotalW = 48;
   localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};
   localparam logic [CountW-1:0] CountCap =
      (MaxBins < (1 << CountW) - 1) ? CountW'(MaxBins) : {CountW{1'b1}};
   localparam logic [29:0] Ln2Q30 = 30'd744261118;

   typedef struct packed {
      logic [31:0] data_count;
      logic [31:0] model_count;
      logic        masked;
      logic        last_bin;
   } req_type;

   typedef struct packed {
      logic [TotalW-1:0] deviance_total;
      logic [CountW-1:0] bins_used;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request, start log of data_count
      logic log_step;  // one squaring iteration
      logic log_m;     // hold data log, switch log unit to model_count
      logic ln_mul;    // log difference and its sign
      logic d_mul;     // log difference times ln 2
      logic term;      // d times ln magnitude, rounded
      logic acc;       // form clamped term
      logic sum;       // add doubled term into total, bump count
      logic emit;      // copy total to output, clear
   } cmd_type;

   typedef struct packed {
      logic last;
   } sts_type;

endpackage

// File: rtl/pda_datapath.sv
module pda_datapath (
   input  logic             clock,
   input  logic             reset,
   input  pda_pkg::req_type req,
   input  pda_pkg::cmd_type cmd,
   output pda_pkg::sts_type sts,
   output pda_pkg::rsp_type rsp_data
);
   import pda_pkg::*;

   logic [31:0] d_ff, m_ff;
   logic        use_ff, last_ff;
   logic [32:0] y_ff, y_in;
   logic [15:0] frac_ff;
   logic [4:0]  exp_ff, exp_in;
   logic [20:0] ld_ff;
   logic [20:0] mag_ff;
   logic        neg_ff;
   logic [50:0] lnprod_ff;
   logic [47:0] dl_ff;
   logic [47:0] term_ff;
   logic [TotalW-1:0] total_ff;
   logic [CountW-1:0] count_ff;
   rsp_type     out_ff;

   logic [31:0] lx;
   logic [65:0] sq;
   logic [32:0] sq_sh;
   logic [20:0] lcur;
   logic [21:0] lnmag;
   logic [53:0] dprod;
   logic signed [49:0] t;
   logic [TotalW:0] headroom;

   always_comb begin
      lx = cmd.load ? req.data_count : m_ff;
      exp_in = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (lx[i]) exp_in = 5'(i);
      end
      y_in = {1'b0, lx << (5'd31 - exp_in)};
      sq = y_ff * y_ff;
      sq_sh = sq[63:31];
      lcur = {exp_ff, frac_ff};
      lnmag = 22'((lnprod_ff + 51'(1 << 29)) >> 30);
      dprod = d_ff * lnmag[20:0];
      t = $signed({18'd0, m_ff}) - $signed({18'd0, d_ff});
      t = neg_ff ? t - $signed({2'b0, dl_ff}) : t + $signed({2'b0, dl_ff});
      headroom = {1'b0, TotalMax} - {1'b0, total_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         d_ff <= req.data_count;
         m_ff <= req.model_count;
         use_ff <= !req.masked && req.data_count != 0 && req.model_count != 0;
         last_ff <= req.last_bin;
      end
      if (cmd.load || cmd.log_m) begin
         y_ff <= y_in;
         exp_ff <= exp_in;
         frac_ff <= '0;
      end else if (cmd.log_step) begin
         // sq_sh < 2^33: keep normalized in [2^31, 2^32)
         if (sq_sh[32]) begin
            y_ff <= {1'b0, sq_sh[32:1]};
            frac_ff <= {frac_ff[14:0], 1'b1};
         end else begin
            y_ff <= sq_sh;
            frac_ff <= {frac_ff[14:0], 1'b0};
         end
      end
      if (cmd.log_m) ld_ff <= lcur;
      if (cmd.ln_mul) begin
         neg_ff <= ld_ff < lcur;
         mag_ff <= (ld_ff < lcur) ? lcur - ld_ff : ld_ff - lcur;
      end
      if (cmd.d_mul) lnprod_ff <= mag_ff * Ln2Q30;
      if (cmd.term) dl_ff <= 48'((dprod + 54'h8000) >> 16);
      if (cmd.acc) term_ff <= t[49] ? '0 : 48'(t);
      if (cmd.emit) out_ff <= '{deviance_total: total_ff, bins_used: count_ff};
   end

   // accumulate the doubled term on the step after it is formed
   logic [48:0] term2;
   assign term2 = {term_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         count_ff <= '0;
      end else if (cmd.emit) begin
         total_ff <= '0;
         count_ff <= '0;
      end else if (cmd.sum && use_ff) begin
         if (term2 >= 49'(headroom)) total_ff <= TotalMax;
         else total_ff <= total_ff + term2[TotalW-1:0];
         if (count_ff < CountCap) count_ff <= count_ff + 1'b1;
      end
   end

   assign sts = '{last: last_ff};
   assign rsp_data = out_ff;
endmodule

// File: rtl/pda_ctrl.sv
module pda_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  pda_pkg::sts_type sts,
   output pda_pkg::cmd_type cmd
);
   import pda_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_LOGD = 4'd1, S_SWAP = 4'd2, S_LOGM = 4'd3,
      S_LN = 4'd4, S_MUL = 4'd5, S_TERM = 4'd6, S_ACC = 4'd7, S_SUM = 4'd8,
      S_FIN = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       vld_ff, vld_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      vld_in = vld_ff && rsp_stall;
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in = '0;
               state_in = S_LOGD;
            end
         end
         S_LOGD, S_LOGM: begin
            cmd.log_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd15) begin
               if (state_ff == S_LOGD) begin
                  state_in = S_SWAP;
               end else begin
                  state_in = S_LN;
               end
            end
         end
         S_SWAP: begin
            cmd.log_m = 1'b1;
            cnt_in = '0;
            state_in = S_LOGM;
         end
         S_LN: begin
            cmd.ln_mul = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.d_mul = 1'b1;
            state_in = S_TERM;
         end
         S_TERM: begin
            cmd.term = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            // on the last bin, emit once the output slot is free; otherwise return to idle
            if (!sts.last) begin
               state_in = S_IDLE;
            end else if (!vld_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               vld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff;
endmodule

// File: rtl/poisson_deviance_accumulator_unit.sv
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | pda_pkg::req_type
// rsp     | out       | rsp_valid/rsp_stall | pda_pkg::rsp_type
//
// One request runs through load, 16 squaring steps of the log unit for
// data_count, one switch step, 16 for model_count, then ln, multiply, term,
// clamp, accumulate and a final step that emits on the last bin.
// The log2 squaring unit is shared by both counts; a new request is taken only once the last one is done.
// Reset (synchronous, active high) clears the total, the count and rsp_valid.
// A stalled response holds; the next request is still taken and only waits
// at its final step if the previous response has not been taken.
module poisson_deviance_accumulator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pda_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pda_pkg::rsp_type rsp_data
);
   import pda_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // controller sequences the request; datapath holds all arithmetic
   pda_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd
   );

   pda_datapath u_dp (
      .clock, .reset, .req(req_data), .cmd, .sts, .rsp_data
   );
endmodule

// File: rtl/pda_checker.sv
module pda_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pda_pkg::rsp_type rsp_data
);
   import pda_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.bins_used <= CountCap)
      else $error("bin count above cap");
endmodule

bind poisson_deviance_accumulator_unit pda_checker u_pda_checker (.*);
